FILE: rtl/hrdip_pkg.sv
// ============================================================================
// hrdip_pkg
// Shared types and constants for the HID report descriptor item parser.
// ============================================================================
package hrdip_pkg;

    localparam int DEF_MAX_DEPTH   = 255;
    localparam int DEF_OFFSET_BITS = 16;

    localparam int TDATA_W   = 128;
    localparam int TD_TYPE_LSB = 0;
    localparam int TD_TAG_LSB  = 2;
    localparam int TD_BAD_BIT  = 122;

    localparam logic [7:0] LONG_PREFIX = 8'hFE;
    localparam logic [1:0] SIZE_CODE_4 = 2'd3;

    localparam logic [1:0] TYPE_MAIN   = 2'd0;
    localparam logic [1:0] TYPE_GLOBAL = 2'd1;
    localparam logic [1:0] TYPE_LOCAL  = 2'd2;

    localparam logic [3:0] TAG_COLLECTION     = 4'd10;
    localparam logic [3:0] TAG_END_COLLECTION = 4'd12;
    localparam logic [3:0] TAG_USAGE_PAGE     = 4'd0;
    localparam logic [3:0] TAG_LOGICAL_MIN    = 4'd1;
    localparam logic [3:0] TAG_LOGICAL_MAX    = 4'd2;
    localparam logic [3:0] TAG_USAGE_MAX      = 4'd2;

    localparam logic [1:0] KIND_SHORT   = 2'd0;
    localparam logic [1:0] KIND_LONG    = 2'd1;
    localparam logic [1:0] KIND_TRUNC   = 2'd2;
    localparam logic [1:0] KIND_SUMMARY = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic        fin;
        logic        maxs;
        logic        bad;
        logic [7:0]  depth;
        logic [15:0] offs;
        logic [15:0] page;
        logic [31:0] sext;
        logic [31:0] raw;
        logic [7:0]  size;
        logic [7:0]  tag;
        logic [1:0]  itype;
    } rec_t;

endpackage

FILE: rtl/hid_report_descriptor_item_parser_core.sv
// ============================================================================
// hid_report_descriptor_item_parser_core
// Splits a HID report descriptor byte stream into item records.
// ============================================================================
// Usage:
//   s_axis carries one descriptor byte per transfer; s_axis_tlast marks the final
//   byte of the descriptor. m_axis carries one record per complete item, a
//   truncation record when the final byte falls inside an item, and a summary
//   record (m_axis_tlast = 1) after the final byte.
//   Parse state is updated in the accept cycle; records land in a two-entry
//   output buffer, so the first record of a byte is valid in the cycle after the
//   byte is accepted. One byte per cycle is sustained while the sink keeps
//   m_axis_tready high; a final byte that yields two records stops input
//   until the first of them is taken.
//   s_axis_tready is high when the buffer is empty, or holds one record that
//   is taken in the same cycle. When the sink stalls, records wait in the
//   buffer and input stops once it is occupied.
//   Reset (aresetn low, synchronous) empties the buffer and returns the parse
//   state to waiting for an item prefix at offset zero. The final byte of a
//   descriptor returns the parser to that same state.
// ============================================================================
module hid_report_descriptor_item_parser_core
    import hrdip_pkg::*;
#(
    parameter int MAX_DEPTH   = DEF_MAX_DEPTH,
    parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // data_byte
    input  logic               s_axis_tlast,   // last_byte
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // item_type, item_tag, data_size, raw_value, sext_value, page_in_effect,
    // prefix_offset, nest_depth, bad_form, max_is_signed, zero pad
    output logic [TDATA_W-1:0] m_axis_tdata,
    output logic [1:0]         m_axis_tuser,   // record_kind
    output logic               m_axis_tlast    // final_record
);

    localparam int DW = $clog2(MAX_DEPTH + 1);

    typedef enum logic [4:0] {
        PH_AWAIT = 5'b00001,
        PH_SHORT = 5'b00010,
        PH_LSIZE = 5'b00100,
        PH_LTAG  = 5'b01000,
        PH_LDATA = 5'b10000
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [7:0]             prefix_reg, prefix_next;
    logic [7:0]             left_reg, left_next;
    logic [31:0]            acc_reg, acc_next;
    logic [7:0]             ltag_reg, ltag_next;
    logic [7:0]             lsize_reg, lsize_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [OFFSET_BITS-1:0] offs_reg, offs_next;
    logic [15:0]            page_reg, page_next;
    logic                   minneg_reg, minneg_next;
    logic [DW-1:0]          depth_reg, depth_next;
    logic                   malf_reg, malf_next;
    logic [15:0]            items_reg, items_next;

    rec_t       q0_reg, q1_reg, q0_next, q1_next;
    logic [1:0] cnt_reg, cnt_next;

    logic       push, pop;
    logic [7:0] b;

    // short item decode
    logic [7:0]  sp;
    logic [31:0] sraw, ssext, acc_or;
    logic [7:0]  ssize;
    logic [1:0]  stype, sidx;
    logic [3:0]  stag;
    logic [7:0]  left_dec;

    logic do_short, do_long, item_bad, item_maxs, trunc;
    rec_t item_rec, trunc_rec, sum_rec, first_rec;
    logic [1:0] n_push;

    function automatic logic [7:0] ssize_of(input logic [7:0] p);
        ssize_of = (p[1:0] == SIZE_CODE_4) ? 8'd4 : {6'b0, p[1:0]};
    endfunction

    assign b    = s_axis_tdata;
    assign pop  = m_axis_tvalid & m_axis_tready;
    assign push = s_axis_tvalid & s_axis_tready;

    assign s_axis_tready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_axis_tready);
    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tuser  = q0_reg.kind;
    assign m_axis_tlast  = q0_reg.fin;
    assign m_axis_tdata  = {4'b0, q0_reg.maxs, q0_reg.bad, q0_reg.depth, q0_reg.offs,
                            q0_reg.page, q0_reg.sext, q0_reg.raw, q0_reg.size,
                            q0_reg.tag, q0_reg.itype};

    assign left_dec = (left_reg != 8'd0) ? left_reg - 8'd1 : 8'd0;

    always_comb begin
        sidx = 2'(ssize_of(prefix_reg) - left_reg);
        case (sidx)
            2'd0:    acc_or = acc_reg | {24'b0, b};
            2'd1:    acc_or = acc_reg | {16'b0, b, 8'b0};
            2'd2:    acc_or = acc_reg | {8'b0, b, 16'b0};
            default: acc_or = acc_reg | {b, 24'b0};
        endcase
        sp    = (phase_reg == PH_AWAIT) ? b : prefix_reg;
        sraw  = (phase_reg == PH_AWAIT) ? 32'd0 : acc_or;
        ssize = ssize_of(sp);
        stype = sp[3:2];
        stag  = sp[7:4];
        ssext = sraw;
        if (ssize == 8'd1 && sraw[7]) begin
            ssext = sraw | 32'hFFFF_FF00;
        end else if (ssize == 8'd2 && sraw[15]) begin
            ssext = sraw | 32'hFFFF_0000;
        end
    end

    always_comb begin
        phase_next  = phase_reg;
        prefix_next = prefix_reg;
        left_next   = left_reg;
        acc_next    = acc_reg;
        ltag_next   = ltag_reg;
        lsize_next  = lsize_reg;
        start_next  = start_reg;
        offs_next   = offs_reg;
        page_next   = page_reg;
        minneg_next = minneg_reg;
        depth_next  = depth_reg;
        malf_next   = malf_reg;
        items_next  = items_reg;
        do_short    = 1'b0;
        do_long     = 1'b0;
        item_bad    = 1'b0;
        item_maxs   = 1'b0;
        item_rec    = '0;
        trunc_rec   = '0;
        sum_rec     = '0;
        trunc       = 1'b0;

        case (phase_reg)
            PH_AWAIT: begin
                start_next  = offs_reg;
                prefix_next = b;
                acc_next    = 32'd0;
                if (b == LONG_PREFIX) begin
                    phase_next = PH_LSIZE;
                end else if (ssize == 8'd0) begin
                    do_short = 1'b1;
                end else begin
                    left_next  = ssize;
                    phase_next = PH_SHORT;
                end
            end
            PH_SHORT: begin
                acc_next  = acc_or;
                left_next = left_dec;
                if (left_dec == 8'd0) begin
                    do_short = 1'b1;
                end
            end
            PH_LSIZE: begin
                lsize_next = b;
                phase_next = PH_LTAG;
            end
            PH_LTAG: begin
                ltag_next = b;
                if (lsize_reg == 8'd0) begin
                    do_long = 1'b1;
                end else begin
                    left_next  = lsize_reg;
                    phase_next = PH_LDATA;
                end
            end
            PH_LDATA: begin
                left_next = left_dec;
                if (left_dec == 8'd0) begin
                    do_long = 1'b1;
                end
            end
            default: begin
                phase_next = PH_AWAIT;
            end
        endcase

        if (do_short) begin
            if (stype == TYPE_MAIN && stag == TAG_COLLECTION) begin
                if (depth_reg < DW'(MAX_DEPTH)) begin
                    depth_next = depth_reg + 1'b1;
                end
            end else if (stype == TYPE_MAIN && stag == TAG_END_COLLECTION) begin
                if (depth_reg == '0) begin
                    item_bad  = 1'b1;
                    malf_next = 1'b1;
                end else begin
                    depth_next = depth_reg - 1'b1;
                end
            end else if (stype == TYPE_GLOBAL && stag == TAG_USAGE_PAGE) begin
                page_next = sraw[15:0];
            end else if (stype == TYPE_GLOBAL && stag == TAG_LOGICAL_MIN) begin
                minneg_next = (ssize != 8'd0) && ssext[31];
            end else if (stype == TYPE_GLOBAL && stag == TAG_LOGICAL_MAX) begin
                item_maxs = minneg_reg;
            end
        end

        if (do_short || do_long) begin
            phase_next = PH_AWAIT;
            if (items_reg != 16'hFFFF) begin
                items_next = items_reg + 16'd1;
            end
        end

        item_rec.offs  = 16'(start_next);
        item_rec.depth = 8'(depth_next);
        item_rec.page  = page_next;
        if (do_short) begin
            item_rec.kind  = KIND_SHORT;
            item_rec.itype = stype;
            item_rec.tag   = {4'b0, stag};
            item_rec.size  = ssize;
            item_rec.raw   = sraw;
            item_rec.sext  = ssext;
            item_rec.bad   = item_bad;
            item_rec.maxs  = item_maxs;
            if (stype == TYPE_LOCAL && stag <= TAG_USAGE_MAX && ssize == 8'd4) begin
                item_rec.page = sraw[31:16];
            end
        end else begin
            item_rec.kind = KIND_LONG;
            item_rec.tag  = (phase_reg == PH_LTAG) ? b : ltag_reg;
            item_rec.size = lsize_next;
        end

        if (s_axis_tlast) begin
            if (phase_next != PH_AWAIT) begin
                trunc     = 1'b1;
                malf_next = 1'b1;
            end
            trunc_rec.kind  = KIND_TRUNC;
            trunc_rec.offs  = 16'(start_next);
            trunc_rec.depth = 8'(depth_next);
            trunc_rec.bad   = 1'b1;

            sum_rec.kind  = KIND_SUMMARY;
            sum_rec.raw   = {16'b0, items_next};
            sum_rec.page  = page_next;
            sum_rec.offs  = 16'(offs_reg);
            sum_rec.depth = 8'(depth_next);
            sum_rec.bad   = malf_next || (depth_next != '0);
            sum_rec.fin   = 1'b1;

            phase_next  = PH_AWAIT;
            prefix_next = 8'd0;
            left_next   = 8'd0;
            acc_next    = 32'd0;
            ltag_next   = 8'd0;
            lsize_next  = 8'd0;
            start_next  = '0;
            offs_next   = '0;
            page_next   = 16'd0;
            minneg_next = 1'b0;
            depth_next  = '0;
            malf_next   = 1'b0;
            items_next  = 16'd0;
        end else begin
            offs_next = offs_reg + 1'b1;
        end

        if (do_short || do_long) begin
            first_rec = item_rec;
        end else if (trunc) begin
            first_rec = trunc_rec;
        end else begin
            first_rec = sum_rec;
        end
        n_push = {1'b0, (do_short | do_long | trunc)} + {1'b0, s_axis_tlast};
    end

    always_comb begin
        q0_next  = q0_reg;
        q1_next  = q1_reg;
        cnt_next = cnt_reg;
        if (pop) begin
            q0_next  = q1_reg;
            cnt_next = cnt_reg - 2'd1;
        end
        if (push) begin
            q0_next  = first_rec;
            q1_next  = sum_rec;
            cnt_next = n_push;
        end
    end

    always_ff @(posedge aclk) begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
        if (!aresetn) begin
            cnt_reg    <= 2'd0;
            phase_reg  <= PH_AWAIT;
            prefix_reg <= 8'd0;
            left_reg   <= 8'd0;
            acc_reg    <= 32'd0;
            ltag_reg   <= 8'd0;
            lsize_reg  <= 8'd0;
            start_reg  <= '0;
            offs_reg   <= '0;
            page_reg   <= 16'd0;
            minneg_reg <= 1'b0;
            depth_reg  <= '0;
            malf_reg   <= 1'b0;
            items_reg  <= 16'd0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                phase_reg  <= phase_next;
                prefix_reg <= prefix_next;
                left_reg   <= left_next;
                acc_reg    <= acc_next;
                ltag_reg   <= ltag_next;
                lsize_reg  <= lsize_next;
                start_reg  <= start_next;
                offs_reg   <= offs_next;
                page_reg   <= page_next;
                minneg_reg <= minneg_next;
                depth_reg  <= depth_next;
                malf_reg   <= malf_next;
                items_reg  <= items_next;
            end
        end
    end

endmodule

FILE: rtl/hrdip_checker.sv
// ============================================================================
// hrdip_checker
// Port-level checks for the HID report descriptor item parser.
// ============================================================================
module hrdip_checker
    import hrdip_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic               s_axis_tlast,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata,
    input logic [1:0]         m_axis_tuser,
    input logic               m_axis_tlast
);

    // final byte always leaves a summary to deliver
    a_last_gives_output: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> m_axis_tvalid)
        else $error("no record after final byte");

    a_last_is_summary: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == KIND_SUMMARY)))
        else $error("tlast does not match summary kind");

    a_trunc_bad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == KIND_TRUNC |-> m_axis_tdata[TD_BAD_BIT])
        else $error("truncation record without bad_form");

    a_summary_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == KIND_SUMMARY
            |-> m_axis_tdata[TD_TAG_LSB+7:TD_TYPE_LSB] == '0)
        else $error("summary carries type or tag");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled record changed");

endmodule

bind hid_report_descriptor_item_parser_core hrdip_checker u_hrdip_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Checks the HID report descriptor item parser record by record. A scoreboard
// class tracks the parse state byte by byte, predicts the records each byte
// yields and compares them with the m_axis output. Stimulus: a short directed
// descriptor set, randomized well-formed, truncated and noisy descriptors,
// and one deep descriptor that saturates the collection depth.
// Both sides idle and stall at random.
// ============================================================================
module testbench;
    import hrdip_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int RANDOM_BYTES = 650;
    localparam int DEEP_ITEMS   = 300;

    // m_axis_tdata layout, low bit first
    localparam int SIZE_LSB  = 10;
    localparam int RAW_LSB   = 18;
    localparam int SEXT_LSB  = 50;
    localparam int PAGE_LSB  = 82;
    localparam int OFFS_LSB  = 98;
    localparam int DEPTH_LSB = 114;
    localparam int MAXS_BIT  = 123;

    typedef enum logic [2:0] {
        AWAIT_PREFIX, SHORT_DATA, LONG_SIZE, LONG_TAG, LONG_DATA
    } parse_phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  itype;
        logic [7:0]  tag;
        logic [7:0]  size;
        logic [31:0] raw;
        logic [31:0] sext;
        logic [15:0] page;
        logic [15:0] offs;
        logic [7:0]  depth;
        logic        bad;
        logic        maxs;
        logic        fin;
    } item_rec_t;

    class hid_item_scoreboard;
        item_rec_t    expected_records[$];
        parse_phase_t phase;
        logic [7:0]   prefix;
        logic [7:0]   left;
        logic [7:0]   ltag_byte;
        logic [7:0]   lsize_byte;
        logic [31:0]  accum;
        logic [15:0]  item_start;
        logic [15:0]  byte_at;
        logic [15:0]  page;
        logic [15:0]  items;
        logic [7:0]   depth;
        bit           min_neg;
        bit           malformed;
        int           errors;
        int           kind_count[4];

        function new();
            clear_state();
            errors = 0;
            foreach (kind_count[k]) kind_count[k] = 0;
        endfunction

        function void clear_state();
            phase      = AWAIT_PREFIX;
            prefix     = '0;
            left       = '0;
            ltag_byte  = '0;
            lsize_byte = '0;
            accum      = '0;
            item_start = '0;
            byte_at    = '0;
            page       = '0;
            items      = '0;
            depth      = '0;
            min_neg    = 1'b0;
            malformed  = 1'b0;
        endfunction

        function logic [7:0] size_of(logic [7:0] p);
            return (p[1:0] == SIZE_CODE_4) ? 8'd4 : {6'd0, p[1:0]};
        endfunction

        function void count_item();
            if (items != 16'hFFFF) items++;
        endfunction

        function void close_short();
            item_rec_t  r;
            logic [7:0] sz;
            logic [1:0] ty;
            logic [3:0] tg;
            logic [31:0] sx;
            logic [15:0] pg;
            bit         bad;
            bit         maxs;
            sz   = size_of(prefix);
            ty   = prefix[3:2];
            tg   = prefix[7:4];
            sx   = accum;
            bad  = 1'b0;
            maxs = 1'b0;
            if (sz == 8'd1 && accum[7])
                sx = {24'hFFFFFF, accum[7:0]};
            else if (sz == 8'd2 && accum[15])
                sx = {16'hFFFF, accum[15:0]};
            if (ty == TYPE_MAIN && tg == TAG_COLLECTION) begin
                if (depth < DEF_MAX_DEPTH) depth++;
            end else if (ty == TYPE_MAIN && tg == TAG_END_COLLECTION) begin
                if (depth == 0) begin
                    bad       = 1'b1;
                    malformed = 1'b1;
                end else begin
                    depth--;
                end
            end else if (ty == TYPE_GLOBAL && tg == TAG_USAGE_PAGE) begin
                page = accum[15:0];
            end else if (ty == TYPE_GLOBAL && tg == TAG_LOGICAL_MIN) begin
                min_neg = (sz != 0) && sx[31];
            end else if (ty == TYPE_GLOBAL && tg == TAG_LOGICAL_MAX) begin
                maxs = min_neg;
            end
            pg = (ty == TYPE_LOCAL && tg <= TAG_USAGE_MAX && sz == 8'd4) ? accum[31:16] : page;
            count_item();
            r = '{kind: KIND_SHORT, itype: ty, tag: {4'd0, tg}, size: sz, raw: accum,
                  sext: sx, page: pg, offs: item_start, depth: depth, bad: bad,
                  maxs: maxs, fin: 1'b0};
            expected_records.push_back(r);
            phase = AWAIT_PREFIX;
        endfunction

        function void close_long();
            item_rec_t r;
            count_item();
            r = '{kind: KIND_LONG, itype: 2'd0, tag: ltag_byte, size: lsize_byte, raw: '0,
                  sext: '0, page: page, offs: item_start, depth: depth, bad: 1'b0,
                  maxs: 1'b0, fin: 1'b0};
            expected_records.push_back(r);
            phase = AWAIT_PREFIX;
        endfunction

        function void note_byte(logic [7:0] b, bit last);
            item_rec_t  r;
            logic [7:0] sz;
            logic [1:0] idx;
            case (phase)
                AWAIT_PREFIX: begin
                    item_start = byte_at;
                    prefix     = b;
                    accum      = '0;
                    if (b == LONG_PREFIX) begin
                        phase = LONG_SIZE;
                    end else if (size_of(b) == 0) begin
                        close_short();
                    end else begin
                        left  = size_of(b);
                        phase = SHORT_DATA;
                    end
                end
                SHORT_DATA: begin
                    sz    = size_of(prefix);
                    idx   = 2'(sz - left);
                    accum = accum | (32'(b) << (8 * idx));
                    if (left > 0) left--;
                    if (left == 0) close_short();
                end
                LONG_SIZE: begin
                    lsize_byte = b;
                    phase      = LONG_TAG;
                end
                LONG_TAG: begin
                    ltag_byte = b;
                    if (lsize_byte == 0) begin
                        close_long();
                    end else begin
                        left  = lsize_byte;
                        phase = LONG_DATA;
                    end
                end
                LONG_DATA: begin
                    if (left > 0) left--;
                    if (left == 0) close_long();
                end
                default: phase = AWAIT_PREFIX;
            endcase
            if (last) begin
                if (phase != AWAIT_PREFIX) begin
                    malformed = 1'b1;
                    r = '{kind: KIND_TRUNC, itype: 2'd0, tag: '0, size: '0, raw: '0,
                          sext: '0, page: '0, offs: item_start, depth: depth, bad: 1'b1,
                          maxs: 1'b0, fin: 1'b0};
                    expected_records.push_back(r);
                end
                r = '{kind: KIND_SUMMARY, itype: 2'd0, tag: '0, size: '0, raw: {16'd0, items},
                      sext: '0, page: page, offs: byte_at, depth: depth,
                      bad: malformed || (depth != 0), maxs: 1'b0, fin: 1'b1};
                expected_records.push_back(r);
                clear_state();
            end else begin
                byte_at = byte_at + 16'd1;
            end
        endfunction

        function void match(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_record(logic [TDATA_W-1:0] td, logic [1:0] tu, logic tl);
            item_rec_t want;
            if (expected_records.size() == 0) begin
                $error("record kind %0d at offset 0x%0h with nothing expected",
                       tu, td[OFFS_LSB +: 16]);
                errors++;
                return;
            end
            want = expected_records.pop_front();
            kind_count[want.kind]++;
            match("record_kind", want.kind, tu);
            match("item_type", want.itype, td[TD_TYPE_LSB +: 2]);
            match("item_tag", want.tag, td[TD_TAG_LSB +: 8]);
            match("data_size", want.size, td[SIZE_LSB +: 8]);
            match("raw_value", want.raw, td[RAW_LSB +: 32]);
            match("sext_value", want.sext, td[SEXT_LSB +: 32]);
            match("page_in_effect", want.page, td[PAGE_LSB +: 16]);
            match("prefix_offset", want.offs, td[OFFS_LSB +: 16]);
            match("nest_depth", want.depth, td[DEPTH_LSB +: 8]);
            match("bad_form", want.bad, td[TD_BAD_BIT]);
            match("max_is_signed", want.maxs, td[MAXS_BIT]);
            match("final_record", want.fin, tl);
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata = '0;
    logic                s_axis_tlast = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]  m_axis_tdata;
    logic [1:0]          m_axis_tuser;
    logic                m_axis_tlast;

    hid_item_scoreboard sb = new();
    logic [7:0] desc_bytes[$];
    int  cycle_count = 0;
    int  burst_left = 0;
    int  bytes_sent = 0;
    int  descriptors = 0;
    bit  quick_run = 1'b0;
    int  sink_mode = 0;
    int  sink_hold = 0;

    hid_report_descriptor_item_parser_core DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #(CLK_HALF) aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_record(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_byte(s_axis_tdata, s_axis_tlast);
        end
    end

    // sink: always ready, mostly ready, one in four, or rarely ready
    always @(posedge aclk) begin
        if (sink_hold == 0) begin
            sink_mode <= quick_run ? $urandom_range(0, 1) : $urandom_range(0, 3);
            sink_hold <= $urandom_range(20, 300);
        end else begin
            sink_hold <= sink_hold - 1;
        end
        case (sink_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 9) < 7);
            2: m_axis_tready <= (cycle_count % 4 == 0);
            default: m_axis_tready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    task automatic send_byte(input logic [7:0] b, input bit last);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            if (quick_run || $urandom_range(0, 9) == 0)
                burst_left = $urandom_range(100, 400);
            else
                burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge aclk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    task automatic play_descriptor();
        foreach (desc_bytes[i])
            send_byte(desc_bytes[i], i == desc_bytes.size() - 1);
        desc_bytes.delete();
        descriptors++;
    endtask

    function automatic logic [7:0] data_value();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic append_item(input int pick);
        logic [7:0] prefix;
        logic [7:0] lsize;
        int         n;
        if (pick < 10)
            prefix = {TAG_USAGE_PAGE, TYPE_GLOBAL, 2'($urandom)};
        else if (pick < 20)
            prefix = {TAG_LOGICAL_MIN, TYPE_GLOBAL, 2'($urandom)};
        else if (pick < 28)
            prefix = {TAG_LOGICAL_MAX, TYPE_GLOBAL, 2'($urandom)};
        else if (pick < 38)
            prefix = {TAG_COLLECTION, TYPE_MAIN, 2'($urandom_range(0, 1))};
        else if (pick < 48)
            prefix = {TAG_END_COLLECTION, TYPE_MAIN, 2'($urandom_range(0, 1))};
        else if (pick < 56)
            prefix = {4'($urandom_range(0, 2)), TYPE_LOCAL, SIZE_CODE_4};
        else if (pick < 66)
            prefix = LONG_PREFIX;
        else
            prefix = 8'($urandom);
        desc_bytes.push_back(prefix);
        if (prefix == LONG_PREFIX) begin
            lsize = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
            desc_bytes.push_back(lsize);
            desc_bytes.push_back(8'($urandom));
            repeat (lsize) desc_bytes.push_back(8'($urandom));
        end else begin
            n = (prefix[1:0] == SIZE_CODE_4) ? 4 : prefix[1:0];
            repeat (n) desc_bytes.push_back(data_value());
        end
    endtask

    initial begin
        int r;
        int base;
        int random_bytes;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // page, negative min then signed max, 4-byte usage, nesting,
        // unmatched end, long items with and without data
        desc_bytes = '{8'h05, 8'h01, 8'h15, 8'h81, 8'h25, 8'h7F,
                       8'h0B, 8'h34, 8'h12, 8'h78, 8'h56,
                       8'hA1, 8'h01, 8'hC0, 8'hC0,
                       8'hFE, 8'h02, 8'h55, 8'hAA, 8'hBB,
                       8'hFE, 8'h00, 8'hFF};
        play_descriptor();
        // final byte inside an item
        desc_bytes = '{8'h27, 8'hFF, 8'hFF};
        play_descriptor();
        // one-byte descriptor
        desc_bytes = '{8'h00};
        play_descriptor();

        random_bytes = 0;
        while (random_bytes < RANDOM_BYTES) begin
            r = $urandom_range(0, 19);
            if (r == 0) begin
                repeat ($urandom_range(1, 12)) desc_bytes.push_back(8'($urandom));
            end else begin
                repeat ($urandom_range(1, 40)) append_item($urandom_range(0, 99));
                if (r < 4) begin
                    do begin
                        base = desc_bytes.size();
                        append_item($urandom_range(0, 99));
                    end while (desc_bytes.size() - base < 2);
                    repeat ($urandom_range(1, desc_bytes.size() - base - 1))
                        void'(desc_bytes.pop_back());
                end
            end
            random_bytes += desc_bytes.size();
            play_descriptor();
        end

        // deep nesting past the depth limit
        quick_run = 1'b1;
        repeat (DEEP_ITEMS) desc_bytes.push_back({TAG_COLLECTION, TYPE_MAIN, 2'b00});
        play_descriptor();
        s_axis_tvalid <= 1'b0;

        while (sb.expected_records.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Sent %0d descriptors, %0d bytes; checked %0d short, %0d long items,",
                 descriptors, bytes_sent, sb.kind_count[KIND_SHORT], sb.kind_count[KIND_LONG]);
        $display("%0d truncations and %0d summaries",
                 sb.kind_count[KIND_TRUNC], sb.kind_count[KIND_SUMMARY]);
        if (sb.errors == 0 && sb.expected_records.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/hrdip_pkg.sv
rtl/hid_report_descriptor_item_parser_core.sv
rtl/hrdip_checker.sv
bench/testbench.sv
